### design/cirm_pkg.sv
// Shared types and constants for the CAN identifier rate monitor.
`timescale 1ns / 1ps
`default_nettype none
package cirm_pkg;
	localparam int unsigned IdW = 29;
	localparam int unsigned RateW = 10;
	localparam logic [RateW-1:0] RateScale = 10'd1000;

	typedef struct packed {
		logic [IdW-1:0] id;
		logic [3:0]     len;
		logic [15:0]    flags;
		logic [63:0]    data;
		logic [31:0]    last_arr;
		logic [31:0]    last_stp;
	} entry_t;

	typedef struct packed {
		logic           write;
		logic [IdW-1:0] id;
	} cell_ctl_t;
endpackage
`default_nettype wire

### design/cirm_cell.sv
// One table cell: holds an entry and shifts it to the next cell while the table rotates.
`timescale 1ns / 1ps
`default_nettype none
module cirm_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            shift,
	input  wire cirm_pkg::entry_t entry_in,
	output cirm_pkg::entry_t     entry_out
);
	import cirm_pkg::*;

	entry_t entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (shift) begin
			entry_q <= entry_in;
		end
	end

	assign entry_out = entry_q;
endmodule
`default_nettype wire

### design/cirm_rate_div.sv
// Restoring divider computing 1000 / d, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module cirm_rate_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [9:0]       quotient
);
	import cirm_pkg::*;

	logic [3:0]  cnt_q;
	logic        busy_q;
	logic [10:0] rem_q;
	logic [9:0]  num_q;
	logic [9:0]  quo_q;
	logic [31:0] div_q;
	logic [32:0] trial;

	assign trial = {22'd0, rem_q[9:0], num_q[9]} - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				rem_q <= '0;
				num_q <= RateScale;
				quo_q <= '0;
				div_q <= (divisor == 32'd0) ? 32'd1 : divisor;
			end else if (busy_q) begin
				num_q <= {num_q[8:0], 1'b0};
				if (!trial[32]) begin
					rem_q <= {1'b0, trial[9:0]};
					quo_q <= {quo_q[8:0], 1'b1};
				end else begin
					rem_q <= {rem_q[9:0], num_q[9]};
					quo_q <= {quo_q[8:0], 1'b0};
				end
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd9) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	assign quotient = quo_q;
endmodule
`default_nettype wire

### design/can_id_rate_monitor.sv
// Top level of the CAN identifier rate monitor.
// Each accepted frame rotates the chain of TABLE_ENTRIES cells once (one cell per cycle) to
// find the first slot holding its identifier or empty and to rewrite that slot on its way
// past, then runs two 10-bit restoring dividers side by side for the rates. A stored frame
// goes through the scan, an align step, the dividers, a mix step and the output register,
// and the next frame can be taken once its result is loaded; a dropped frame skips the
// dividers and the mix step. One frame is handled at a time; a frame may be taken while
// the previous result waits, but its own result holds until the waiting one is taken.
// A full table drops the frame with status 1 and all other fields zero.
`timescale 1ns / 1ps
`default_nettype none
module can_id_rate_monitor #(
	parameter int unsigned TABLE_ENTRIES = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [28:0] frame_id,
	input  wire logic [3:0]  frame_length,
	input  wire logic [15:0] frame_flags,
	input  wire logic [63:0] payload,
	input  wire logic [31:0] hw_stamp,
	input  wire logic [31:0] arrival_time,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             status,
	output logic [4:0]       slot,
	output logic             payload_changed,
	output logic [31:0]      arrival_delta,
	output logic [31:0]      stamp_delta,
	output logic [9:0]       arrival_rate,
	output logic [9:0]       stamp_rate
);
	import cirm_pkg::*;

	localparam int unsigned CntW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	typedef enum logic [2:0] {IDLE, SCAN, ALIGN, DIV, MIX, OUT} state_t;

	state_t state_q;
	logic [CntW:0] cnt_q;
	logic [CntW:0] found_q;
	logic hit_q;
	logic [28:0] id_q;
	logic [3:0] len_q;
	logic [15:0] flags_q;
	logic [63:0] data_q;
	logic [31:0] stamp_q, now_q;
	entry_t hold_q;
	logic [RateW-1:0] old_ra_q, old_rs_q;
	logic [9:0] qa_q, qs_q;

	entry_t chain [TABLE_ENTRIES+1];
	entry_t head;
	logic shift;
	logic scan_hit;
	logic out_load;
	cell_ctl_t ctl;
	logic div_start, done_a, done_s;
	logic [9:0] quo_a, quo_s;
	logic [31:0] d_arr, d_stp;
	logic [12:0] mix_a, mix_s;
	logic [25:0] prod_a, prod_s;
	logic [RateW-1:0] new_ra, new_rs;

	// smoothed rates live in a side register file indexed by slot; they are only
	// known after the pass has moved on
	logic [2*RateW-1:0] rates_q [TABLE_ENTRIES];
	logic [2*RateW-1:0] rate_rd;

	genvar g;
	generate
		for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
			cirm_cell u_cell (.clk(clk), .arst_n(arst_n), .shift(shift),
				.entry_in(chain[g]), .entry_out(chain[g+1]));
		end
	endgenerate

	// search the tail cell, which holds slot cnt_q
	assign scan_hit = (state_q == SCAN) && !hit_q &&
		(chain[TABLE_ENTRIES].id == '0 || chain[TABLE_ENTRIES].id == id_q);

	// tail entry comes back to the head; the matching entry is replaced on its way past
	assign ctl.id = id_q;
	assign ctl.write = scan_hit;
	always_comb begin
		head = chain[TABLE_ENTRIES];
		if (ctl.write) begin
			head.id = ctl.id;
			head.len = len_q;
			head.flags = flags_q;
			head.data = data_q;
			head.last_arr = now_q;
			head.last_stp = stamp_q;
		end
	end
	assign chain[0] = head;
	assign shift = (state_q == SCAN);

	assign d_arr = now_q - hold_q.last_arr;
	assign d_stp = stamp_q - hold_q.last_stp;
	assign div_start = (state_q == ALIGN);

	cirm_rate_div u_div_a (.clk(clk), .arst_n(arst_n), .start(div_start), .divisor(d_arr),
		.done(done_a), .quotient(quo_a));
	cirm_rate_div u_div_s (.clk(clk), .arst_n(arst_n), .start(div_start), .divisor(d_stp),
		.done(done_s), .quotient(quo_s));

	assign mix_a = {2'd0, qa_q, 1'b0} + 13'(3 * old_ra_q);
	assign mix_s = {2'd0, qs_q, 1'b0} + 13'(3 * old_rs_q);

	// divide by 5 as multiply by 6554 and shift by 15, exact for sums below 16384
	assign prod_a = 26'(mix_a) * 26'd6554;
	assign prod_s = 26'(mix_s) * 26'd6554;
	assign new_ra = prod_a[24:15];
	assign new_rs = prod_s[24:15];

	assign rate_rd = rates_q[found_q[CntW-1:0]];

	assign in_ready = (state_q == IDLE);
	assign out_load = (state_q == OUT) && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			out_valid <= 1'b0;
			cnt_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (out_load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			case (state_q)
				IDLE: begin
					if (in_valid && in_ready) begin
						id_q <= frame_id; len_q <= frame_length; flags_q <= frame_flags;
						data_q <= payload; stamp_q <= hw_stamp; now_q <= arrival_time;
						hit_q <= 1'b0;
						cnt_q <= '0;
						state_q <= SCAN;
					end
				end
				SCAN: begin
					if (scan_hit) begin
						hit_q <= 1'b1;
						found_q <= cnt_q;
						hold_q <= chain[TABLE_ENTRIES];
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == (CntW+1)'(TABLE_ENTRIES - 1)) state_q <= ALIGN;
				end
				ALIGN: begin
					if (hit_q) begin
						old_ra_q <= rate_rd[9:0];
						old_rs_q <= rate_rd[19:10];
					end
					state_q <= hit_q ? DIV : OUT;
				end
				DIV: if (done_a) begin
					qa_q <= quo_a; qs_q <= quo_s; state_q <= MIX;
				end
				MIX: state_q <= OUT;
				OUT: begin
					// hold until the previous result has been taken
					if (out_load) begin
						status <= !hit_q;
						slot <= hit_q ? 5'(found_q) : 5'd0;
						payload_changed <= hit_q && (hold_q.data != data_q);
						arrival_delta <= hit_q ? d_arr : 32'd0;
						stamp_delta <= hit_q ? d_stp : 32'd0;
						arrival_rate <= hit_q ? new_ra : 10'd0;
						stamp_rate <= hit_q ? new_rs : 10'd0;
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) rates_q[i] <= '0;
		end else if (state_q == MIX) begin
			rates_q[found_q[CntW-1:0]] <= {new_rs, new_ra};
		end
	end

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		done_a == done_s) else $error("dividers out of step");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != IDLE) |-> !in_ready) else $error("accept while busy");
	a_out_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == OUT)) else $error("stray result");
endmodule
`default_nettype wire

### test/tb_can_id_rate_monitor.sv
// Testbench for can_id_rate_monitor: directed and random frames checked against a table predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_can_id_rate_monitor;
	localparam int unsigned NumSlots = 32;

	typedef struct packed {
		logic [28:0] id;
		logic [3:0]  len;
		logic [15:0] flags;
		logic [63:0] data;
		logic [31:0] stamp;
		logic [31:0] now;
	} frame_t;

	typedef struct packed {
		logic        full;
		logic [4:0]  slot;
		logic        changed;
		logic [31:0] d_arr;
		logic [31:0] d_stp;
		logic [9:0]  r_arr;
		logic [9:0]  r_stp;
	} report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_ready = 1'b0;
	logic in_ready, out_valid;
	logic [28:0] frame_id = '0;
	logic [3:0]  frame_length = '0;
	logic [15:0] frame_flags = '0;
	logic [63:0] payload = '0;
	logic [31:0] hw_stamp = '0;
	logic [31:0] arrival_time = '0;
	logic status, payload_changed;
	logic [4:0] slot;
	logic [31:0] arrival_delta, stamp_delta;
	logic [9:0] arrival_rate, stamp_rate;

	can_id_rate_monitor #(.TABLE_ENTRIES(NumSlots)) DUT (.*);

	always #2 clk = ~clk;

	// predictor copy of the identifier table
	logic [28:0] tbl_id [NumSlots];
	logic [63:0] tbl_data [NumSlots];
	logic [31:0] tbl_arr [NumSlots];
	logic [31:0] tbl_stp [NumSlots];
	logic [9:0]  tbl_rarr [NumSlots];
	logic [9:0]  tbl_rstp [NumSlots];

	frame_t  pending_frames[$];
	report_t expected_reports[$];
	int errors = 0;
	int n_sent = 0;
	int n_full = 0;
	int n_stored = 0;
	bit stim_done = 1'b0;
	bit long_done = 1'b0;
	int hold_off = 0;
	int gap = 0;

	function automatic logic [9:0] smoothed(logic [31:0] delta, logic [9:0] old);
		logic [31:0] d;
		logic [31:0] inst;
		d = (delta == 0) ? 32'd1 : delta;
		inst = 32'd1000 / d;
		return 10'((2 * inst + 3 * old) / 5);
	endfunction

	function automatic report_t predict_frame(frame_t f);
		report_t r;
		int hit;
		hit = -1;
		r = '0;
		for (int i = 0; i < NumSlots; i++)
			if (hit < 0 && (tbl_id[i] == 0 || tbl_id[i] == f.id)) hit = i;
		if (hit < 0) begin
			r.full = 1'b1;
			return r;
		end
		r.slot = 5'(hit);
		r.changed = tbl_data[hit] != f.data;
		r.d_arr = f.now - tbl_arr[hit];
		r.d_stp = f.stamp - tbl_stp[hit];
		r.r_arr = smoothed(r.d_arr, tbl_rarr[hit]);
		r.r_stp = smoothed(r.d_stp, tbl_rstp[hit]);
		tbl_id[hit] = f.id;
		tbl_data[hit] = f.data;
		tbl_arr[hit] = f.now;
		tbl_stp[hit] = f.stamp;
		tbl_rarr[hit] = r.r_arr;
		tbl_rstp[hit] = r.r_stp;
		return r;
	endfunction

	function automatic int short_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) :
			($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 3));
	endfunction

	// sender
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				n_sent <= n_sent + 1;
				expected_reports.push_back(predict_frame({frame_id, frame_length,
					frame_flags, payload, hw_stamp, arrival_time}));
			end
			if (!in_valid || in_ready) begin
				if (gap > 0) begin
					gap <= gap - 1;
					in_valid <= 1'b0;
				end else if (pending_frames.size() > 0) begin
					frame_t f;
					f = pending_frames.pop_front();
					in_valid <= 1'b1;
					{frame_id, frame_length, frame_flags, payload, hw_stamp,
						arrival_time} <= f;
					gap <= short_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				report_t e;
				if (expected_reports.size() == 0) begin
					$error("unexpected result transfer");
					errors++;
				end else begin
					e = expected_reports.pop_front();
					if (status) n_full++; else n_stored++;
					if (status !== e.full) begin
						$error("status exp %0d got %0d", e.full, status); errors++; end
					if (slot !== e.slot) begin
						$error("slot exp %0d got %0d", e.slot, slot); errors++; end
					if (payload_changed !== e.changed) begin
						$error("payload_changed exp %0d got %0d", e.changed,
							payload_changed); errors++; end
					if (arrival_delta !== e.d_arr) begin
						$error("arrival_delta exp %0d got %0d", e.d_arr,
							arrival_delta); errors++; end
					if (stamp_delta !== e.d_stp) begin
						$error("stamp_delta exp %0d got %0d", e.d_stp,
							stamp_delta); errors++; end
					if (arrival_rate !== e.r_arr) begin
						$error("arrival_rate exp %0d got %0d", e.r_arr,
							arrival_rate); errors++; end
					if (stamp_rate !== e.r_stp) begin
						$error("stamp_rate exp %0d got %0d", e.r_stp,
							stamp_rate); errors++; end
				end
			end
			// long hold-off once early, to back up the input side
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_ready <= 1'b0;
			end else if (!long_done && n_sent >= 40) begin
				long_done <= 1'b1;
				hold_off <= 400;
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 19) == 0) begin
				hold_off <= $urandom_range(5, 50);
				out_ready <= 1'b0;
			end else begin
				out_ready <= $urandom_range(0, 3) != 0;
			end
		end
	end

	function automatic frame_t rand_frame(logic [28:0] id, logic [31:0] now,
			logic [31:0] stamp);
		frame_t f;
		f.id = id;
		f.len = 4'($urandom);
		f.flags = 16'($urandom);
		f.data = ($urandom_range(0, 3) == 0) ? 64'h0 : {$urandom, $urandom};
		f.stamp = stamp;
		f.now = now;
		return f;
	endfunction

	initial begin
		logic [28:0] ids [48];
		logic [31:0] t_arr, t_stp;
		frame_t f;
		for (int i = 0; i < NumSlots; i++) begin
			tbl_id[i] = '0; tbl_data[i] = '0; tbl_arr[i] = '0;
			tbl_stp[i] = '0; tbl_rarr[i] = '0; tbl_rstp[i] = '0;
		end
		// directed: extremes, zero and large deltas, identifier zero
		pending_frames.push_back('{29'h1FFFFFFF, 4'hF, 16'hFFFF, '1, '1, '1});
		pending_frames.push_back('{29'h1FFFFFFF, 4'h0, 16'h0, '1, '1, '1});
		pending_frames.push_back('{29'h1FFFFFFF, 4'h0, 16'h0, '0, 32'd0, 32'd0});
		pending_frames.push_back('{29'h0, 4'h5, 16'h1234, 64'h55, 32'd7, 32'd3});
		pending_frames.push_back('{29'h0, 4'h5, 16'h1234, 64'h55, 32'd7, 32'd3});
		pending_frames.push_back('{29'h1, 4'h1, 16'h1, 64'h1, 32'd1000, 32'd1001});
		pending_frames.push_back('{29'h1, 4'h1, 16'h1, 64'h1, 32'd1010, 32'd1011});
		pending_frames.push_back('{29'h1, 4'h1, 16'h1, 64'h2, 32'd5000, 32'd1012});
		// random: a working set of ids with small time steps, plus fresh ids
		// that eventually fill the table and hit the full case
		for (int i = 0; i < 48; i++) ids[i] = 29'($urandom) | 29'd1;
		t_arr = $urandom; t_stp = $urandom;
		for (int n = 0; n < 900; n++) begin
			t_arr += ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40);
			t_stp += ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40);
			f = rand_frame(ids[$urandom_range(0, (n < 300) ? 20 : 47)], t_arr, t_stp);
			if ($urandom_range(0, 49) == 0) f.id = 29'($urandom);
			pending_frames.push_back(f);
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_frames.size() == 0 && !in_valid);
		wait (expected_reports.size() == 0);
		repeat (200) @(posedge clk);
		$display("frames sent %0d: %0d stored, %0d dropped on full table",
			n_sent, n_stored, n_full);
		if (errors == 0 && expected_reports.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire
